// ===== rtl/core/sorted_sparse_vector_table_macros.svh =====
// Assertion macros for the sorted sparse vector table checker.
// Expects clk_i and rst_ni in the scope where they are used.
`ifndef SORTED_SPARSE_VECTOR_TABLE_MACROS_SVH
`define SORTED_SPARSE_VECTOR_TABLE_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define SSVT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ssvt assertion failed");

// Same-cycle implication.
`define SSVT_IMPLIES(lbl, a, b) `SSVT_ASSERT(lbl, (a) |-> (b))

`endif

// ===== rtl/core/ssvt_pkg.sv =====
// Shared types, codes and defaults for the sorted sparse vector table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ssvt_pkg;

  localparam int DefCapacity = 256;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_SCALE = 2'd2;
  localparam logic [1:0] OP_NORM  = 2'd3;

  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  // datapath actions
  localparam logic [4:0] A_NONE     = 5'd0;
  localparam logic [4:0] A_START    = 5'd1;
  localparam logic [4:0] A_SRCH_RD  = 5'd2;
  localparam logic [4:0] A_SRCH_UPD = 5'd3;
  localparam logic [4:0] A_POS_RD   = 5'd4;
  localparam logic [4:0] A_SET_WR   = 5'd5;
  localparam logic [4:0] A_ADD_WR   = 5'd6;
  localparam logic [4:0] A_FULL     = 5'd7;
  localparam logic [4:0] A_SH_INIT  = 5'd8;
  localparam logic [4:0] A_SH_RD    = 5'd9;
  localparam logic [4:0] A_SH_WR    = 5'd10;
  localparam logic [4:0] A_INS_WR   = 5'd11;
  localparam logic [4:0] A_ITER_RD  = 5'd12;
  localparam logic [4:0] A_MUL      = 5'd13;
  localparam logic [4:0] A_SC_WR    = 5'd14;
  localparam logic [4:0] A_NM_ACC   = 5'd15;
  localparam logic [4:0] A_SQ_INIT  = 5'd16;
  localparam logic [4:0] A_SQ_STEP  = 5'd17;
  localparam logic [4:0] A_OUT      = 5'd18;

  typedef struct packed {
    logic [4:0] act;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic lo_lt_fill;
    logic rd_eq_key;
    logic full;
    logic i_gt_lo;
    logic i_lt_fill;
    logic sq_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/ssvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ssvt_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/ssvt_ctrl.sv =====
// Sequencer for the sorted sparse vector table: issues datapath actions.
// Depends on ssvt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssvt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    op_i,
  output logic               in_stall_o,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  input  wire ssvt_pkg::stat_t stat_i,
  output ssvt_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRCH   = 4'd1;
  localparam logic [3:0] S_SRCH_W = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_INS    = 4'd4;
  localparam logic [3:0] S_SH     = 4'd5;
  localparam logic [3:0] S_SH_W   = 4'd6;
  localparam logic [3:0] S_SC     = 4'd7;
  localparam logic [3:0] S_SC_W   = 4'd8;
  localparam logic [3:0] S_SC_MUL = 4'd9;
  localparam logic [3:0] S_NM     = 4'd10;
  localparam logic [3:0] S_NM_W   = 4'd11;
  localparam logic [3:0] S_NM_MUL = 4'd12;
  localparam logic [3:0] S_SQ     = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  logic       out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d          = state_q;
    op_d             = op_q;
    cmd_o.act        = ssvt_pkg::A_NONE;
    cmd_o.load_out   = 1'b0;
    out_valid_d      = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = ssvt_pkg::A_START;
          op_d      = op_i;
          if (op_i == ssvt_pkg::OP_SCALE) begin
            state_d = S_SC;
          end else if (op_i == ssvt_pkg::OP_NORM) begin
            state_d = S_NM;
          end else begin
            state_d = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (stat_i.lo_lt_hi) begin
          cmd_o.act = ssvt_pkg::A_SRCH_RD;
          state_d   = S_SRCH_W;
        end else if (stat_i.lo_lt_fill) begin
          cmd_o.act = ssvt_pkg::A_POS_RD;
          state_d   = S_CHK;
        end else begin
          state_d = S_INS;
        end
      end
      S_SRCH_W: begin
        cmd_o.act = ssvt_pkg::A_SRCH_UPD;
        state_d   = S_SRCH;
      end
      S_CHK: begin
        if (stat_i.rd_eq_key) begin
          cmd_o.act = (op_q == ssvt_pkg::OP_SET) ? ssvt_pkg::A_SET_WR : ssvt_pkg::A_ADD_WR;
          state_d   = S_DONE;
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        if (stat_i.full) begin
          cmd_o.act = ssvt_pkg::A_FULL;
          state_d   = S_DONE;
        end else begin
          cmd_o.act = ssvt_pkg::A_SH_INIT;
          state_d   = S_SH;
        end
      end
      S_SH: begin
        if (stat_i.i_gt_lo) begin
          cmd_o.act = ssvt_pkg::A_SH_RD;
          state_d   = S_SH_W;
        end else begin
          cmd_o.act = ssvt_pkg::A_INS_WR;
          state_d   = S_DONE;
        end
      end
      S_SH_W: begin
        cmd_o.act = ssvt_pkg::A_SH_WR;
        state_d   = S_SH;
      end
      S_SC: begin
        if (stat_i.i_lt_fill) begin
          cmd_o.act = ssvt_pkg::A_ITER_RD;
          state_d   = S_SC_W;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SC_W: begin
        cmd_o.act = ssvt_pkg::A_MUL;
        state_d   = S_SC_MUL;
      end
      S_SC_MUL: begin
        cmd_o.act = ssvt_pkg::A_SC_WR;
        state_d   = S_SC;
      end
      S_NM: begin
        if (stat_i.i_lt_fill) begin
          cmd_o.act = ssvt_pkg::A_ITER_RD;
          state_d   = S_NM_W;
        end else begin
          cmd_o.act = ssvt_pkg::A_SQ_INIT;
          state_d   = S_SQ;
        end
      end
      S_NM_W: begin
        cmd_o.act = ssvt_pkg::A_MUL;
        state_d   = S_NM_MUL;
      end
      S_NM_MUL: begin
        cmd_o.act = ssvt_pkg::A_NM_ACC;
        state_d   = S_NM;
      end
      S_SQ: begin
        cmd_o.act = ssvt_pkg::A_SQ_STEP;
        if (stat_i.sq_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to drain
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= ssvt_pkg::OP_SET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ssvt_datapath.sv =====
// Datapath: counters, RAMs, multiplier, accumulator, square root, outputs.
// Depends on ssvt_pkg and ssvt_ram.
`timescale 1ns / 1ps
`default_nettype none
module ssvt_datapath #(
  parameter int CAPACITY = ssvt_pkg::DefCapacity
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [1:0]    op_i,
  input  wire logic [31:0]   index_i,
  input  wire logic [31:0]   value_i,
  input  wire ssvt_pkg::cmd_t cmd_i,
  output ssvt_pkg::stat_t    stat_o,
  output logic [1:0]         status_o,
  output logic               saturated_o,
  output logic [31:0]        norm_o,
  output logic [8:0]         element_count_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [1:0]  op_q;
  logic [31:0] key_q;
  logic [31:0] val_q;
  logic [CW-1:0] lo_q, hi_q, i_q, fill_q;
  logic [1:0]  st_q;
  logic        sat_q;
  logic signed [63:0] prod_q;
  logic [63:0] sum_q, x_q, res_q, bit_q;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] im1;
  logic [AW-1:0] raddr, waddr;
  logic          idx_we, val_we;
  logic [31:0]   idx_wdata, val_wdata, idx_rd, val_rd;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CW:1];
  assign im1     = i_q - 1'b1;

  // add with saturation
  logic signed [32:0] add_s;
  logic [31:0]        add_clip;
  logic               add_ovf;
  assign add_s   = {val_rd[31], val_rd} + {val_q[31], val_q};
  assign add_ovf = add_s[32] != add_s[31];
  assign add_clip = add_ovf ? (add_s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : add_s[31:0];

  // Q16.16 product rounding, ties toward plus infinity
  logic signed [63:0] rnd, q16;
  logic               sc_hi, sc_lo;
  logic [31:0]        sc_clip;
  assign rnd   = prod_q + 64'sd32768;
  assign q16   = rnd >>> 16;
  assign sc_hi = q16 > 64'sd2147483647;
  assign sc_lo = q16 < -64'sd2147483648;
  assign sc_clip = sc_hi ? 32'h7FFF_FFFF : (sc_lo ? 32'h8000_0000 : q16[31:0]);

  logic [64:0] acc;
  assign acc = {1'b0, sum_q} + {1'b0, prod_q};

  logic [63:0] trial;
  logic        take;
  assign trial = res_q + bit_q;
  assign take  = x_q >= trial;

  logic signed [31:0] mul_b;
  assign mul_b = (op_q == ssvt_pkg::OP_SCALE) ? val_q : val_rd;

  always_comb begin
    raddr     = lo_q[AW-1:0];
    waddr     = lo_q[AW-1:0];
    idx_we    = 1'b0;
    val_we    = 1'b0;
    idx_wdata = key_q;
    val_wdata = val_q;
    case (cmd_i.act)
      ssvt_pkg::A_SRCH_RD: raddr = mid[AW-1:0];
      ssvt_pkg::A_SET_WR:  val_we = 1'b1;
      ssvt_pkg::A_ADD_WR: begin
        val_we    = 1'b1;
        val_wdata = add_clip;
      end
      ssvt_pkg::A_SH_RD: raddr = im1[AW-1:0];
      ssvt_pkg::A_SH_WR: begin
        waddr     = i_q[AW-1:0];
        idx_we    = 1'b1;
        val_we    = 1'b1;
        idx_wdata = idx_rd;
        val_wdata = val_rd;
      end
      ssvt_pkg::A_INS_WR: begin
        idx_we = 1'b1;
        val_we = 1'b1;
      end
      ssvt_pkg::A_ITER_RD: raddr = i_q[AW-1:0];
      ssvt_pkg::A_SC_WR: begin
        waddr     = i_q[AW-1:0];
        val_we    = 1'b1;
        val_wdata = sc_clip;
      end
      default: begin
        raddr = lo_q[AW-1:0];
      end
    endcase
  end

  ssvt_ram #(.Width(32), .Depth(CAPACITY)) u_idx_ram (
    .clk_i   (clk_i),
    .we_i    (idx_we),
    .waddr_i (waddr),
    .wdata_i (idx_wdata),
    .raddr_i (raddr),
    .rdata_o (idx_rd)
  );

  ssvt_ram #(.Width(32), .Depth(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (waddr),
    .wdata_i (val_wdata),
    .raddr_i (raddr),
    .rdata_o (val_rd)
  );

  assign stat_o.lo_lt_hi   = lo_q < hi_q;
  assign stat_o.lo_lt_fill = lo_q < fill_q;
  assign stat_o.rd_eq_key  = idx_rd == key_q;
  assign stat_o.full       = fill_q == CW'(CAPACITY);
  assign stat_o.i_gt_lo    = i_q > lo_q;
  assign stat_o.i_lt_fill  = i_q < fill_q;
  assign stat_o.sq_last    = bit_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.act == ssvt_pkg::A_INS_WR) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      ssvt_pkg::A_START: begin
        op_q  <= op_i;
        key_q <= index_i;
        val_q <= value_i;
        lo_q  <= '0;
        hi_q  <= fill_q;
        i_q   <= '0;
        sat_q <= 1'b0;
        sum_q <= '0;
        st_q  <= ssvt_pkg::ST_DONE;
      end
      ssvt_pkg::A_SRCH_UPD: begin
        if (idx_rd < key_q) begin
          lo_q <= mid + 1'b1;
        end else begin
          hi_q <= mid;
        end
      end
      ssvt_pkg::A_SET_WR: st_q <= ssvt_pkg::ST_UPDATED;
      ssvt_pkg::A_ADD_WR: begin
        st_q  <= ssvt_pkg::ST_UPDATED;
        sat_q <= add_ovf;
      end
      ssvt_pkg::A_FULL:    st_q <= ssvt_pkg::ST_FULL;
      ssvt_pkg::A_SH_INIT: i_q  <= fill_q;
      ssvt_pkg::A_SH_WR:   i_q  <= im1;
      ssvt_pkg::A_INS_WR:  st_q <= ssvt_pkg::ST_INSERTED;
      ssvt_pkg::A_MUL:     prod_q <= $signed(val_rd) * mul_b;
      ssvt_pkg::A_SC_WR: begin
        i_q <= i_q + 1'b1;
        if (sc_hi || sc_lo) begin
          sat_q <= 1'b1;
        end
      end
      ssvt_pkg::A_NM_ACC: begin
        i_q <= i_q + 1'b1;
        if (acc[64]) begin
          sum_q <= '1;
          sat_q <= 1'b1;
        end else begin
          sum_q <= acc[63:0];
        end
      end
      ssvt_pkg::A_SQ_INIT: begin
        x_q   <= sum_q;
        res_q <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      ssvt_pkg::A_SQ_STEP: begin
        if (take) begin
          x_q   <= x_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: begin
        st_q <= st_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o        <= st_q;
      saturated_o     <= sat_q;
      norm_o          <= (op_q == ssvt_pkg::OP_NORM) ? res_q[31:0] : 32'd0;
      element_count_o <= 9'(fill_q);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_sparse_vector_table.sv =====
// Set and add binary-search the stored keys: a match is updated, a new key is inserted
// by shifting each later entry up one slot, or dropped when the table is full.
// Scale and norm walk all stored entries; the norm takes one square-root bit per cycle.
// Next input taken in the cycle after the result loads.
// Reset clears the entry count and handshake state; the RAMs are not cleared.
// Depends on ssvt_pkg, ssvt_ctrl, ssvt_datapath.
`timescale 1ns / 1ps
`default_nettype none
module sorted_sparse_vector_table #(
  parameter int CAPACITY = ssvt_pkg::DefCapacity
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] index_i,
  input  wire logic [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic             saturated_o,
  output logic [31:0]      norm_o,
  output logic [8:0]       element_count_o
);

  ssvt_pkg::cmd_t  cmd;
  ssvt_pkg::stat_t stat;

  ssvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ssvt_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op_i),
    .index_i         (index_i),
    .value_i         (value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .status_o        (status_o),
    .saturated_o     (saturated_o),
    .norm_o          (norm_o),
    .element_count_o (element_count_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/ssvt_checker.sv =====
// Port-level assertions for sorted_sparse_vector_table, bound to the top.
// Depends on ssvt_pkg and sorted_sparse_vector_table_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_sparse_vector_table_macros.svh"
module ssvt_checker #(
  parameter int CAPACITY = ssvt_pkg::DefCapacity
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  status_o,
  input wire logic        saturated_o,
  input wire logic [31:0] norm_o,
  input wire logic [8:0]  element_count_o
);

  `SSVT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `SSVT_ASSERT(a_one_at_a_time, in_valid_i && !in_stall_o |=> in_stall_o)
  `SSVT_IMPLIES(a_norm_only_done, out_valid_o && status_o != ssvt_pkg::ST_DONE, norm_o == 32'd0)
  `SSVT_IMPLIES(a_full_count, out_valid_o && status_o == ssvt_pkg::ST_FULL, !saturated_o && element_count_o == 9'(CAPACITY))

endmodule

bind sorted_sparse_vector_table ssvt_checker #(.CAPACITY(CAPACITY)) u_ssvt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .saturated_o     (saturated_o),
  .norm_o          (norm_o),
  .element_count_o (element_count_o)
);
`default_nettype wire

// ===== tb/sv/sorted_sparse_vector_table_tb.sv =====
// Self-checking testbench for sorted_sparse_vector_table: directed rows, then random traffic.
// Each result is compared against the row's typed answer or an in-bench predictor of the sorted table.
// Depends on ssvt_pkg and the sorted_sparse_vector_table RTL.
`timescale 1ns / 1ps
module sorted_sparse_vector_table_tb;

  localparam int Depth = 256;
  localparam int NumRandom = 1930;

  typedef struct packed {
    logic [1:0]  status;
    logic        saturated;
    logic [31:0] norm;
    logic [8:0]  count;
  } answer_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] index;
    logic [31:0] value;
    bit          typed;
    answer_t     answer;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = ssvt_pkg::OP_NORM;
  logic [31:0] index_i = '0;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        saturated_o;
  logic [31:0] norm_o;
  logic [8:0]  element_count_o;

  logic [31:0] key_tab[Depth];
  logic signed [31:0] val_tab[Depth];
  int unsigned fill = 0;
  answer_t pending[$];
  bit failed = 1'b0;
  bit calm = 1'b0;

  always #5 clk_i = ~clk_i;

  sorted_sparse_vector_table dut (.*);

  function automatic logic signed [31:0] clip(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] floor_sqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res[31:0];
  endfunction

  // Applies one item to the shadow table and returns the answer it should give.
  function automatic answer_t table_apply(logic [1:0] op, logic [31:0] key,
                                          logic signed [31:0] val);
    answer_t a;
    bit sat = 1'b0;
    int unsigned pos = 0;
    longint prod;
    longint unsigned sum = 0, sq;
    a.status = ssvt_pkg::ST_DONE;
    a.norm = '0;
    if (op == ssvt_pkg::OP_SET || op == ssvt_pkg::OP_ADD) begin
      while (pos < fill && key_tab[pos] < key) pos++;
      if (pos < fill && key_tab[pos] == key) begin
        if (op == ssvt_pkg::OP_SET) val_tab[pos] = val;
        else val_tab[pos] = clip(longint'(val_tab[pos]) + longint'(val), sat);
        a.status = ssvt_pkg::ST_UPDATED;
      end else if (fill >= Depth) begin
        a.status = ssvt_pkg::ST_FULL;
      end else begin
        for (int i = fill; i > pos; i--) begin
          key_tab[i] = key_tab[i-1];
          val_tab[i] = val_tab[i-1];
        end
        key_tab[pos] = key;
        val_tab[pos] = val;
        fill++;
        a.status = ssvt_pkg::ST_INSERTED;
      end
    end else if (op == ssvt_pkg::OP_SCALE) begin
      for (int i = 0; i < fill; i++) begin
        prod = (longint'(val_tab[i]) * longint'(val) + 32768) >>> 16;
        val_tab[i] = clip(prod, sat);
      end
    end else begin
      for (int i = 0; i < fill; i++) begin
        sq = longint'(val_tab[i]) * longint'(val_tab[i]);
        if (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin
          sum = 64'hFFFF_FFFF_FFFF_FFFF;
          sat = 1'b1;
        end else begin
          sum += sq;
        end
      end
      a.norm = floor_sqrt(sum);
    end
    a.saturated = sat;
    a.count = fill[8:0];
    return a;
  endfunction

  task automatic send(logic [1:0] op, logic [31:0] key, logic [31:0] val,
                      bit typed, answer_t typed_ans);
    answer_t a;
    while (!calm && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    index_i <= key;
    value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    a = table_apply(op, key, val);
    pending.push_back(typed ? typed_ans : a);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 38);
  end

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d sat=%0b norm=%h count=%0d", $time,
                 status_o, saturated_o, norm_o, element_count_o);
        failed = 1'b1;
      end else begin
        e = pending.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          failed = 1'b1;
        end
        if (saturated_o !== e.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time, e.saturated,
                   saturated_o);
          failed = 1'b1;
        end
        if (norm_o !== e.norm) begin
          $display("%0t: norm expected %h actual %h", $time, e.norm, norm_o);
          failed = 1'b1;
        end
        if (element_count_o !== e.count) begin
          $display("%0t: element_count expected %0d actual %0d", $time, e.count,
                   element_count_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    row_t rows[$];
    answer_t none;
    logic [1:0] op;
    logic [31:0] key, val;
    int unsigned roll;
    none = '0;
    // typed rows: empty table, extremes, add overflow, norm sum overflow
    rows = '{
      '{ssvt_pkg::OP_NORM,  32'd0,        32'h0,        1,
        '{ssvt_pkg::ST_DONE, 1'b0, 32'd0, 9'd0}},
      '{ssvt_pkg::OP_SCALE, 32'd0,        32'h10000,    1,
        '{ssvt_pkg::ST_DONE, 1'b0, 32'd0, 9'd0}},
      '{ssvt_pkg::OP_SET,   32'd5,        32'h0,        1,
        '{ssvt_pkg::ST_INSERTED, 1'b0, 32'd0, 9'd1}},
      '{ssvt_pkg::OP_SET,   32'hFFFFFFFF, 32'h7FFFFFFF, 1,
        '{ssvt_pkg::ST_INSERTED, 1'b0, 32'd0, 9'd2}},
      '{ssvt_pkg::OP_SET,   32'd0,        32'h80000000, 1,
        '{ssvt_pkg::ST_INSERTED, 1'b0, 32'd0, 9'd3}},
      '{ssvt_pkg::OP_ADD,   32'hFFFFFFFF, 32'h1,        1,
        '{ssvt_pkg::ST_UPDATED, 1'b1, 32'd0, 9'd3}},
      '{ssvt_pkg::OP_ADD,   32'd0,        32'hFFFFFFFF, 1,
        '{ssvt_pkg::ST_UPDATED, 1'b1, 32'd0, 9'd3}},
      '{ssvt_pkg::OP_ADD,   32'd7,        32'h10000,    1,
        '{ssvt_pkg::ST_INSERTED, 1'b0, 32'd0, 9'd4}},
      '{ssvt_pkg::OP_SET,   32'd5,        32'h30000,    1,
        '{ssvt_pkg::ST_UPDATED, 1'b0, 32'd0, 9'd4}},
      '{ssvt_pkg::OP_NORM,  32'd0,        32'h0,        0, none},
      '{ssvt_pkg::OP_SCALE, 32'd0,        32'h7FFFFFFF, 0, none},
      '{ssvt_pkg::OP_SCALE, 32'd0,        32'h8000,     0, none},
      '{ssvt_pkg::OP_SCALE, 32'd0,        32'hFFFF8000, 0, none},
      '{ssvt_pkg::OP_NORM,  32'd0,        32'h0,        0, none},
      '{ssvt_pkg::OP_SCALE, 32'd0,        32'h0,        1,
        '{ssvt_pkg::ST_DONE, 1'b0, 32'd0, 9'd4}},
      '{ssvt_pkg::OP_NORM,  32'd0,        32'h0,        1,
        '{ssvt_pkg::ST_DONE, 1'b0, 32'd0, 9'd4}},
      '{ssvt_pkg::OP_SET,   32'd0,        32'h80000000, 0, none},
      '{ssvt_pkg::OP_SET,   32'd1,        32'h80000000, 0, none},
      '{ssvt_pkg::OP_SET,   32'd2,        32'h80000000, 0, none},
      '{ssvt_pkg::OP_SET,   32'd3,        32'h80000000, 0, none},
      '{ssvt_pkg::OP_NORM,  32'd0,        32'h0,        1,
        '{ssvt_pkg::ST_DONE, 1'b1, 32'hFFFFFFFF, 9'd7}},
      '{ssvt_pkg::OP_SCALE, 32'd0,        32'h00000001, 0, none}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[r]) send(rows[r].op, rows[r].index, rows[r].value, rows[r].typed,
                           rows[r].answer);
    // hold off until the directed answers are all back
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 600 && n < 800);
      roll = $urandom_range(99);
      if (roll < 38) op = ssvt_pkg::OP_SET;
      else if (roll < 76) op = ssvt_pkg::OP_ADD;
      else if (roll < 86) op = ssvt_pkg::OP_SCALE;
      else op = ssvt_pkg::OP_NORM;
      // small key pool fills the table and forces drops; some full-width keys
      roll = $urandom_range(99);
      if (roll < 85) key = $urandom_range(399);
      else if (roll < 95) key = $urandom();
      else key = roll[0] ? 32'hFFFFFFFF : 32'h0;
      if (op == ssvt_pkg::OP_SCALE) begin
        roll = $urandom_range(99);
        if (roll < 80) val = $urandom_range(32'h18000, 32'h8000);
        else if (roll < 90) val = -$urandom_range(32'h18000, 32'h8000);
        else val = $urandom();
      end else begin
        roll = $urandom_range(99);
        if (roll < 50) val = $urandom();
        else if (roll < 90) val = $signed($urandom_range(32'h40000)) - 32'sh20000;
        else val = roll[0] ? 32'h7FFFFFFF : 32'h80000000;
      end
      send(op, key, val, 1'b0, none);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!failed && pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ssvt_pkg.sv
rtl/core/ssvt_ram.sv
rtl/core/ssvt_ctrl.sv
rtl/core/ssvt_datapath.sv
rtl/core/sorted_sparse_vector_table.sv
rtl/core/ssvt_checker.sv
tb/sv/sorted_sparse_vector_table_tb.sv
